>>> hdl/fan_tachometer_rpm_defines.svh
// ----------------------------------------------------------------------------
// Fan tachometer assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FAN_TACHOMETER_RPM_DEFINES_SVH
`define FAN_TACHOMETER_RPM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ftr_pkg.sv
// ----------------------------------------------------------------------------
// Fan tachometer package
// Widths, reset values, register indexes, shared types and the rate scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftr_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 32;
    localparam int COUNT_WIDTH_DEFAULT = 24;
    localparam int WINDOW_WIDTH        = 32;
    localparam int RATE_WIDTH          = 27;
    localparam int PPR_WIDTH           = 5;
    localparam int RPM_WIDTH           = 24;
    localparam int SCALED_RATE_WIDTH   = RATE_WIDTH + 6;
    localparam int APB_ADDR_WIDTH      = 4;
    localparam int APB_DATA_WIDTH      = 32;

    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 32'd1000000;
    localparam logic [RATE_WIDTH-1:0]   RATE_RESET   = 27'd1000000;
    localparam logic [PPR_WIDTH-1:0]    PPR_RESET    = 5'd2;
    localparam logic [RPM_WIDTH-1:0]    RPM_MAX      = '1;

    typedef enum logic [1:0] {
        REG_WINDOW = 2'd0,
        REG_RATE   = 2'd1,
        REG_PPR    = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        SEQ_IDLE = 4'b0001,
        SEQ_MUL  = 4'b0010,
        SEQ_DIV  = 4'b0100,
        SEQ_DONE = 4'b1000
    } seq_state_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_status_t;

    // Ticks per second times sixty, as (rate << 6) - (rate << 2).
    function automatic logic [SCALED_RATE_WIDTH-1:0] scale_rate(
        input logic [RATE_WIDTH-1:0] rate
    );
        return {rate, 6'b0} - {4'b0, rate, 2'b0};
    endfunction

endpackage

>>> hdl/ftr_addsub.sv
// ----------------------------------------------------------------------------
// Fan tachometer shared adder
// One add or subtract with carry out, used by every arithmetic step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftr_addsub #(
    parameter int WIDTH = 62
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] result,
    output logic             carry
);

    // On a subtract the carry out is set when a is not below b.
    assign {carry, result} = {1'b0, a} + {1'b0, b ^ {WIDTH{sub}}} + (WIDTH + 1)'(sub);

endmodule

>>> hdl/ftr_window.sv
// ----------------------------------------------------------------------------
// Fan tachometer window front end
// Falling edge detection, window timing and edge tick capture.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftr_window #(
    parameter int TIMER_WIDTH = 32,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick,
    input  logic                            tach_level,
    input  logic [ftr_pkg::WINDOW_WIDTH-1:0] window_ticks,
    output logic                            last_tick,
    output logic                            win_end,
    output logic [COUNT_WIDTH-1:0]          edge_total,
    output logic [TIMER_WIDTH-1:0]          span
);

    import ftr_pkg::*;

    localparam int EW = ((TIMER_WIDTH > WINDOW_WIDTH) ? TIMER_WIDTH : WINDOW_WIDTH) + 1;

    logic                   prev_level_reg, prev_level_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [COUNT_WIDTH-1:0] edges_reg, edges_next;
    logic [TIMER_WIDTH-1:0] first_reg, first_next;
    logic [TIMER_WIDTH-1:0] last_reg, last_next;

    logic [WINDOW_WIDTH-1:0] win_len;
    logic [EW-1:0]           elapsed_inc;
    logic                    fall;
    logic [COUNT_WIDTH-1:0]  edges_upd;
    logic [TIMER_WIDTH-1:0]  first_upd;
    logic [TIMER_WIDTH-1:0]  last_upd;

    // A zero window length behaves as a single tick.
    assign win_len     = (window_ticks == '0) ? WINDOW_WIDTH'(1) : window_ticks;
    assign elapsed_inc = EW'(elapsed_reg) + EW'(1);
    assign last_tick   = !(elapsed_inc < EW'(win_len)) || (&elapsed_reg);

    assign fall      = prev_level_reg & ~tach_level;
    assign edges_upd = (fall && !(&edges_reg)) ? edges_reg + COUNT_WIDTH'(1) : edges_reg;
    assign first_upd = (fall && edges_reg == '0) ? elapsed_reg : first_reg;
    assign last_upd  = fall ? elapsed_reg : last_reg;

    assign win_end    = tick & last_tick;
    assign edge_total = edges_upd;
    assign span       = last_upd - first_upd;

    always_comb
    begin
        prev_level_next = prev_level_reg;
        elapsed_next    = elapsed_reg;
        edges_next      = edges_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        if (tick)
        begin
            prev_level_next = tach_level;
            if (last_tick)
            begin
                elapsed_next = '0;
                edges_next   = '0;
                first_next   = '0;
                last_next    = '0;
            end
            else
            begin
                elapsed_next = elapsed_reg + TIMER_WIDTH'(1);
                edges_next   = edges_upd;
                first_next   = first_upd;
                last_next    = last_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            elapsed_reg    <= '0;
            edges_reg      <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
        end
        else
        begin
            prev_level_reg <= prev_level_next;
            elapsed_reg    <= elapsed_next;
            edges_reg      <= edges_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
        end
    end

endmodule

>>> hdl/ftr_seq.sv
// ----------------------------------------------------------------------------
// Fan tachometer arithmetic sequencer
// Shift-add multiply then restoring divide on one shared adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftr_seq #(
    parameter int TIMER_WIDTH = 32,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [COUNT_WIDTH-1:0]             edge_total,
    input  logic [TIMER_WIDTH-1:0]             span,
    input  logic [ftr_pkg::RATE_WIDTH-1:0]     tick_rate_hz,
    input  logic [ftr_pkg::PPR_WIDTH-1:0]      pulses_per_rev,
    input  logic                               take,
    output ftr_pkg::seq_status_t               status,
    output logic [ftr_pkg::RPM_WIDTH-1:0]      rpm,
    output logic [ftr_pkg::RPM_WIDTH-1:0]      edge_count,
    output logic                               stalled
);

    import ftr_pkg::*;

    localparam int NW  = COUNT_WIDTH + SCALED_RATE_WIDTH;
    localparam int DW  = TIMER_WIDTH + PPR_WIDTH;
    localparam int SHW = DW + RPM_WIDTH;
    localparam int UW  = ((NW > SHW) ? NW : SHW) + 1;
    localparam int SMX = (COUNT_WIDTH > RPM_WIDTH + 1) ? COUNT_WIDTH : RPM_WIDTH + 1;
    localparam int SW  = $clog2(SMX);
    localparam int XW  = (COUNT_WIDTH > RPM_WIDTH) ? COUNT_WIDTH : RPM_WIDTH;

    seq_state_t                   state_reg, state_next;
    logic [SW-1:0]                step_reg, step_next;
    logic [UW-1:0]                acc_reg, acc_next;
    logic [UW-1:0]                dsh_reg, dsh_next;
    logic [COUNT_WIDTH-1:0]       mplier_reg, mplier_next;
    logic [SCALED_RATE_WIDTH-1:0] rate_reg, rate_next;
    logic [RPM_WIDTH-1:0]         q_reg, q_next;
    logic [RPM_WIDTH-1:0]         count_reg, count_next;
    logic                         stalled_reg, stalled_next;

    logic [PPR_WIDTH-1:0] ppr_eff;
    logic [DW-1:0]        denom;
    logic                 few;
    logic [RPM_WIDTH-1:0] count_sat;
    logic [UW-1:0]        unit_a, unit_b, unit_res;
    logic                 unit_sub, unit_carry;

    assign ppr_eff   = (pulses_per_rev == '0) ? PPR_WIDTH'(1) : pulses_per_rev;
    assign denom     = DW'(ppr_eff) * DW'(span);
    assign few       = edge_total <= COUNT_WIDTH'(2);
    assign count_sat = (XW'(edge_total) > XW'(RPM_MAX)) ? RPM_MAX : RPM_WIDTH'(edge_total);

    // Multiply: acc = 2*acc + (bit ? rate : 0). Divide: acc - (denom << step).
    assign unit_sub = (state_reg == SEQ_DIV);
    assign unit_a   = unit_sub ? acc_reg : {acc_reg[UW-2:0], 1'b0};
    assign unit_b   = unit_sub ? dsh_reg
                               : (mplier_reg[COUNT_WIDTH-1] ? UW'(rate_reg) : '0);

    ftr_addsub #(
        .WIDTH (UW)
    ) u_addsub (
        .a      (unit_a),
        .b      (unit_b),
        .sub    (unit_sub),
        .result (unit_res),
        .carry  (unit_carry)
    );

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        acc_next     = acc_reg;
        dsh_next     = dsh_reg;
        mplier_next  = mplier_reg;
        rate_next    = rate_reg;
        q_next       = q_reg;
        count_next   = count_reg;
        stalled_next = stalled_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    count_next   = count_sat;
                    stalled_next = few;
                    mplier_next  = edge_total - COUNT_WIDTH'(1);
                    rate_next    = scale_rate(tick_rate_hz);
                    dsh_next     = UW'({denom, {RPM_WIDTH{1'b0}}});
                    acc_next     = '0;
                    q_next       = '0;
                    step_next    = SW'(COUNT_WIDTH - 1);
                    state_next   = few ? SEQ_DONE : SEQ_MUL;
                end
            end
            SEQ_MUL:
            begin
                acc_next    = unit_res;
                mplier_next = {mplier_reg[COUNT_WIDTH-2:0], 1'b0};
                if (step_reg == '0)
                begin
                    step_next  = SW'(RPM_WIDTH);
                    state_next = SEQ_DIV;
                end
                else
                begin
                    step_next = step_reg - SW'(1);
                end
            end
            SEQ_DIV:
            begin
                if (unit_carry)
                begin
                    acc_next = unit_res;
                end
                dsh_next  = {1'b0, dsh_reg[UW-1:1]};
                q_next    = {q_reg[RPM_WIDTH-2:0], unit_carry};
                step_next = step_reg - SW'(1);
                // A quotient bit above the result width means saturation.
                if (step_reg == SW'(RPM_WIDTH) && unit_carry)
                begin
                    q_next     = RPM_MAX;
                    state_next = SEQ_DONE;
                end
                else if (step_reg == '0)
                begin
                    state_next = SEQ_DONE;
                end
            end
            SEQ_DONE:
            begin
                if (take)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        dsh_reg     <= dsh_next;
        mplier_reg  <= mplier_next;
        rate_reg    <= rate_next;
        q_reg       <= q_next;
        count_reg   <= count_next;
        stalled_reg <= stalled_next;
    end

    assign status.idle = (state_reg == SEQ_IDLE);
    assign status.done = (state_reg == SEQ_DONE);
    assign rpm         = q_reg;
    assign edge_count  = count_reg;
    assign stalled     = stalled_reg;

endmodule

>>> hdl/fan_tachometer_rpm.sv
// ----------------------------------------------------------------------------
// Fan tachometer RPM meter
// Each input word is one timebase tick with the sampled tach line. Falling
// edges are counted in back-to-back windows of window_ticks ticks, and at the
// end of every window one output word carries rpm, edge_count and stalled.
// rpm = (edges - 1) * tick_rate_hz * 60 / (pulses_per_rev * span), where span
// runs from the first to the last edge tick; it is 0 with two or fewer edges.
// The user writes configuration through the APB port only while no window
// result is in flight; the block does not enforce it. pready is always high
// and reads return the register values. A tick that does not end a window is
// always accepted. The tick that ends a window starts the shared adder:
// COUNT_WIDTH shift-add multiply steps, then up to 25 restoring divide
// steps, before the result goes to the output word; a stalled window skips
// both, and early saturation ends the divide at its first step. Meanwhile
// the next window-ending tick waits. A finished result is held in the output
// register while the receiver stalls, and a second one waits behind it.
// Reset clears the window, sets the previous tach level high and loads the
// register defaults (1000000 ticks, 1000000 Hz, 2 pulses per revolution).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_tachometer_rpm #(
    parameter int TIMER_WIDTH = ftr_pkg::TIMER_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = ftr_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ftr_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [ftr_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [ftr_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                tach_level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ftr_pkg::RPM_WIDTH-1:0]       rpm,
    output logic [ftr_pkg::RPM_WIDTH-1:0]       edge_count,
    output logic                                stalled
);

    import ftr_pkg::*;

`include "fan_tachometer_rpm_defines.svh"

    // Configuration registers.
    logic [WINDOW_WIDTH-1:0] window_ticks_reg, window_ticks_next;
    logic [RATE_WIDTH-1:0]   tick_rate_reg, tick_rate_next;
    logic [PPR_WIDTH-1:0]    ppr_reg, ppr_next;

    // Output word register.
    logic                 out_valid_reg, out_valid_next;
    logic [RPM_WIDTH-1:0] rpm_reg, rpm_next;
    logic [RPM_WIDTH-1:0] edge_count_reg, edge_count_next;
    logic                 stalled_reg, stalled_next;

    logic                   cfg_write;
    reg_index_t             reg_index;
    logic                   tick;
    logic                   last_tick;
    logic                   win_end;
    logic [COUNT_WIDTH-1:0] edge_total;
    logic [TIMER_WIDTH-1:0] span;
    seq_status_t            seq_status;
    logic                   take;
    logic [RPM_WIDTH-1:0]   seq_rpm;
    logic [RPM_WIDTH-1:0]   seq_edge_count;
    logic                   seq_stalled;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign reg_index = reg_index_t'(paddr[APB_ADDR_WIDTH-1:2]);

    always_comb
    begin
        window_ticks_next = window_ticks_reg;
        tick_rate_next    = tick_rate_reg;
        ppr_next          = ppr_reg;
        prdata            = '0;
        case (reg_index)
            REG_WINDOW:
            begin
                prdata = APB_DATA_WIDTH'(window_ticks_reg);
                if (cfg_write)
                begin
                    window_ticks_next = pwdata[WINDOW_WIDTH-1:0];
                end
            end
            REG_RATE:
            begin
                prdata = APB_DATA_WIDTH'(tick_rate_reg);
                if (cfg_write)
                begin
                    tick_rate_next = pwdata[RATE_WIDTH-1:0];
                end
            end
            REG_PPR:
            begin
                prdata = APB_DATA_WIDTH'(ppr_reg);
                if (cfg_write)
                begin
                    ppr_next = pwdata[PPR_WIDTH-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // A tick is refused only when it would close a window while the
    // sequencer is still busy with the previous one.
    assign in_ready = seq_status.idle | ~last_tick;
    assign tick     = in_valid & in_ready;

    ftr_window #(
        .TIMER_WIDTH (TIMER_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .tach_level   (tach_level),
        .window_ticks (window_ticks_reg),
        .last_tick    (last_tick),
        .win_end      (win_end),
        .edge_total   (edge_total),
        .span         (span)
    );

    ftr_seq #(
        .TIMER_WIDTH (TIMER_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (win_end),
        .edge_total     (edge_total),
        .span           (span),
        .tick_rate_hz   (tick_rate_reg),
        .pulses_per_rev (ppr_reg),
        .take           (take),
        .status         (seq_status),
        .rpm            (seq_rpm),
        .edge_count     (seq_edge_count),
        .stalled        (seq_stalled)
    );

    // The finished word moves to the output register once it is free
    // or being drained in the same cycle.
    assign take = seq_status.done & (~out_valid_reg | out_ready);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        rpm_next        = rpm_reg;
        edge_count_next = edge_count_reg;
        stalled_next    = stalled_reg;
        if (take)
        begin
            out_valid_next  = 1'b1;
            rpm_next        = seq_rpm;
            edge_count_next = seq_edge_count;
            stalled_next    = seq_stalled;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg <= WINDOW_RESET;
            tick_rate_reg    <= RATE_RESET;
            ppr_reg          <= PPR_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            window_ticks_reg <= window_ticks_next;
            tick_rate_reg    <= tick_rate_next;
            ppr_reg          <= ppr_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rpm_reg        <= rpm_next;
        edge_count_reg <= edge_count_next;
        stalled_reg    <= stalled_next;
    end

    assign out_valid  = out_valid_reg;
    assign rpm        = rpm_reg;
    assign edge_count = edge_count_reg;
    assign stalled    = stalled_reg;

    // A window must not close while the previous result is still in work.
    `FTR_ASSERT_SAME(a_busy_holds_window_end, clk, rst_n, (!seq_status.idle && last_tick), !in_ready, "window end accepted while sequencer busy")
    // A stalled word always reports zero speed.
    `FTR_ASSERT_SAME(a_stalled_rpm_zero, clk, rst_n, (out_valid && stalled), (rpm == '0), "stalled word with nonzero rpm")
    // A measured word needs more edges than any stalled word has.
    `FTR_ASSERT_SAME(a_measured_edges, clk, rst_n, (out_valid && !stalled), (edge_count > RPM_WIDTH'(2)), "measured word with too few edges")
    // A finished result stays in the sequencer until it is taken.
    `FTR_ASSERT_NEXT(a_result_held, clk, rst_n, (seq_status.done && !take), seq_status.done, "finished result dropped before transfer")

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Fan tachometer RPM meter testbench
// Sends tach samples one tick per word and predicts the window readings, then
// checks every reading word field by field in arrival order. It writes the
// window length, tick rate and pulses per revolution over APB between phases,
// and it varies source gaps and sink stalls, including one long sink hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import ftr_pkg::*;

    // Enough idle cycles for a window reading to leave the divider.
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_TICKS  = 400;
    localparam int RANDOM_READS  = 48;
    localparam logic [23:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [RPM_WIDTH-1:0] rpm;
        logic [RPM_WIDTH-1:0] edge_count;
        logic                 stalled;
    } tach_reading_t;

    typedef enum {
        TRAFFIC_STEADY,
        TRAFFIC_SLOW_SOURCE,
        TRAFFIC_SLOW_SINK,
        TRAFFIC_SLOW_BOTH
    } traffic_t;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_ready;
    logic                      tach_level;
    logic                      out_valid;
    logic                      out_ready;
    logic [RPM_WIDTH-1:0]      rpm;
    logic [RPM_WIDTH-1:0]      edge_count;
    logic                      stalled;

    // Register copies, as the block holds them after reset.
    logic [WINDOW_WIDTH-1:0] cfg_window = WINDOW_RESET;
    logic [RATE_WIDTH-1:0]   cfg_rate   = RATE_RESET;
    logic [PPR_WIDTH-1:0]    cfg_ppr    = PPR_RESET;

    // Window state of the predictor.
    logic        last_level     = 1'b1;
    logic [31:0] tick_in_window = '0;
    logic [23:0] edge_total     = '0;
    logic [31:0] first_edge_at  = '0;
    logic [31:0] last_edge_at   = '0;

    tach_reading_t expected_readings[$];
    tach_reading_t oldest_reading;

    int error_count   = 0;
    int readings_seen = 0;
    int ticks_sent    = 0;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_left     = 0;

    fan_tachometer_rpm u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .tach_level (tach_level),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rpm        (rpm),
        .edge_count (edge_count),
        .stalled    (stalled)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // A run that hangs ends here; the slowest correct run is far shorter.
    initial
    begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // Advances the window by one accepted tick and queues the reading that a
    // window end produces. A falling edge is a low tick after a high tick, and
    // the previous level carries over window boundaries.
    function automatic void advance_tach_window(input logic level);
        logic [32:0]   win_eff;
        logic [31:0]   span;
        logic [4:0]    ppr_eff;
        logic [63:0]   numer;
        logic [63:0]   denom;
        logic [63:0]   quot;
        tach_reading_t reading;
        if (last_level && !level)
        begin
            if (edge_total == 0)
                first_edge_at = tick_in_window;
            last_edge_at = tick_in_window;
            if (edge_total != COUNT_MAX)
                edge_total++;
        end
        last_level = level;

        // A zero window length behaves as one tick; the tick counter never
        // wraps, so a window ends at the latest on its last value.
        win_eff = (cfg_window == 0) ? 33'd1 : {1'b0, cfg_window};
        if ({1'b0, tick_in_window} + 33'd1 < win_eff && tick_in_window != 32'hFFFF_FFFF)
        begin
            tick_in_window++;
            return;
        end

        reading.rpm        = '0;
        reading.edge_count = edge_total;
        reading.stalled    = 1'b1;
        if (edge_total > 2)
        begin
            // Exact integer math: the numerator stays below 2^57.
            reading.stalled = 1'b0;
            span    = last_edge_at - first_edge_at;
            ppr_eff = (cfg_ppr == 0) ? 5'd1 : cfg_ppr;
            denom   = 64'(ppr_eff) * 64'(span);
            numer   = 64'(edge_total - 24'd1) * (64'(cfg_rate) * 64'd60);
            if (denom == 0)
                reading.rpm = RPM_MAX;
            else
            begin
                quot = numer / denom;
                reading.rpm = (quot > 64'(RPM_MAX)) ? RPM_MAX : quot[RPM_WIDTH-1:0];
            end
        end
        expected_readings.push_back(reading);

        tick_in_window = '0;
        edge_total     = '0;
        first_edge_at  = '0;
        last_edge_at   = '0;
    endfunction

    // Sink side: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Every reading word is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            readings_seen++;
            if (expected_readings.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected reading, expected none, got rpm %0d edges %0d stalled %0d",
                         $time, rpm, edge_count, stalled);
            end
            else
            begin
                oldest_reading = expected_readings.pop_front();
                if (rpm !== oldest_reading.rpm)
                begin
                    error_count++;
                    $display("%0t: rpm mismatch, expected %0d, got %0d",
                             $time, oldest_reading.rpm, rpm);
                end
                if (edge_count !== oldest_reading.edge_count)
                begin
                    error_count++;
                    $display("%0t: edge_count mismatch, expected %0d, got %0d",
                             $time, oldest_reading.edge_count, edge_count);
                end
                if (stalled !== oldest_reading.stalled)
                begin
                    error_count++;
                    $display("%0t: stalled mismatch, expected %0d, got %0d",
                             $time, oldest_reading.stalled, stalled);
                end
            end
        end
    end

    task automatic set_traffic(input traffic_t mode);
        case (mode)
            TRAFFIC_STEADY:      begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            TRAFFIC_SLOW_SOURCE: begin src_idle_pct = 64; sink_stall_pct = 0;  end
            TRAFFIC_SLOW_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 64; end
            default:             begin src_idle_pct = 21; sink_stall_pct = 21; end
        endcase
    endtask

    // APB write: setup cycle, then access cycle until pready, then psel drops and
    // the bus idles before it may be used again.
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WINDOW: cfg_window = value;
            REG_RATE:   cfg_rate   = value[RATE_WIDTH-1:0];
            REG_PPR:    cfg_ppr    = value[PPR_WIDTH-1:0];
            default:    ;
        endcase
        @(posedge clk);
    endtask

    // One tick word; valid stays up after acceptance unless a gap follows.
    task automatic send_tick(input logic level);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        tach_level <= level;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_tach_window(level);
        ticks_sent++;
    endtask

    // Sends count levels, most significant bit first.
    task automatic send_levels(input logic [31:0] levels, input int count);
        for (int i = count - 1; i >= 0; i--)
            send_tick(levels[i]);
    endtask

    // Stops the source until every reading is in, then lets a reading that a
    // non-final tick may still have in flight drain out.
    task automatic wait_for_readings();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Zero window acts as one tick, so every tick gives a reading, and an
    // edge lands on the first tick of a window.
    task automatic test_short_windows();
        write_reg(REG_WINDOW, 32'd0);
        send_levels(32'b10010, 5);
        wait_for_readings();
    endtask

    // Alternating levels at the reset rate and pulse count:
    // 3 * 60e6 / (2 * 6) gives 15000000, just under the field maximum.
    task automatic test_rpm_math();
        write_reg(REG_WINDOW, 32'd8);
        send_levels(32'b10101010, 8);
        wait_for_readings();
    endtask

    // Largest rate with zero pulses per revolution (taken as one) saturates.
    task automatic test_rpm_saturation();
        write_reg(REG_RATE, 32'h07FF_FFFF);
        write_reg(REG_PPR, 32'd0);
        write_reg(REG_WINDOW, 32'd6);
        send_levels(32'b101010, 6);
        wait_for_readings();
    endtask

    // Zero tick rate gives rpm 0 even with enough edges.
    task automatic test_zero_rate();
        write_reg(REG_RATE, 32'd0);
        write_reg(REG_PPR, 32'd31);
        send_levels(32'b101010, 6);
        wait_for_readings();
    endtask

    // Every tick ends a window while the sink holds off, so readings back up
    // into the block and it has to refuse ticks until the sink resumes.
    task automatic test_output_backpressure();
        set_traffic(TRAFFIC_STEADY);
        write_reg(REG_RATE, 32'd1000);
        write_reg(REG_PPR, 32'd2);
        write_reg(REG_WINDOW, 32'd1);
        hold_left = 300;
        for (int i = 0; i < 20; i++)
            send_tick(1'($urandom_range(1)));
        wait_for_readings();
    endtask

    // Phases of periodic tach waveforms with noise, each phase under fresh
    // register values and one of the traffic patterns.
    task automatic test_random_traffic();
        int       phase;
        int       start_ticks;
        int       start_reads;
        int       phase_ticks;
        int       burst_left;
        int       period;
        int       high_len;
        int       pos;
        logic     level;
        phase       = 0;
        start_ticks = ticks_sent;
        start_reads = readings_seen;
        period      = 4;
        high_len    = 2;
        pos         = 0;
        burst_left  = 0;
        while (ticks_sent - start_ticks < RANDOM_TICKS ||
               readings_seen - start_reads < RANDOM_READS)
        begin
            wait_for_readings();
            set_traffic(traffic_t'(phase % 4));
            case ($urandom_range(5))
                0:       write_reg(REG_RATE, 32'd1);
                1:       write_reg(REG_RATE, 32'd1000);
                2:       write_reg(REG_RATE, 32'd100000000);
                3:       write_reg(REG_RATE, 32'h07FF_FFFF);
                default: write_reg(REG_RATE, $urandom_range(1, 5000000));
            endcase
            case ($urandom_range(4))
                0:       write_reg(REG_PPR, 32'd0);
                1:       write_reg(REG_PPR, 32'd1);
                2:       write_reg(REG_PPR, 32'd16);
                3:       write_reg(REG_PPR, 32'd31);
                default: write_reg(REG_PPR, $urandom_range(1, 16));
            endcase
            case ($urandom_range(9))
                0:       write_reg(REG_WINDOW, 32'd0);
                1:       write_reg(REG_WINDOW, 32'd1);
                2:       write_reg(REG_WINDOW, $urandom_range(100, 200));
                default: write_reg(REG_WINDOW, $urandom_range(3, 40));
            endcase

            phase_ticks = $urandom_range(25, 45);
            for (int i = 0; i < phase_ticks; i++)
            begin
                if (burst_left == 0)
                begin
                    period     = $urandom_range(2, 12);
                    high_len   = $urandom_range(1, period - 1);
                    burst_left = $urandom_range(8, 30);
                end
                burst_left--;
                pos   = (pos + 1) % period;
                level = (pos < high_len);
                // Glitches on the tach line break up the clean pulse train.
                if ($urandom_range(99) < 10)
                    level = 1'($urandom_range(1));
                send_tick(level);
            end
            phase++;
        end
        wait_for_readings();
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        in_valid   <= 1'b0;
        tach_level <= 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_windows();
        test_rpm_math();
        test_rpm_saturation();
        test_zero_rate();
        test_output_backpressure();
        test_random_traffic();

        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
